// File: sv/gsrm_pkg.sv
package gsrm_pkg;

    localparam int TICK_W    = 20;
    localparam int DIST_W    = 16;
    localparam int NOISE_W   = 21;
    localparam int LEVEL_W   = 24;
    localparam int NOISY_W   = 26;
    localparam int RT_W      = 16;
    localparam int DEN_W     = 26;
    localparam int MAG_W     = 42;
    localparam int HALF_W    = 21;
    localparam int MPY_W     = HALF_W + TICK_W;
    localparam int ACC_W     = MPY_W + HALF_W;
    localparam int DIVD_W    = 61;
    localparam int DIFF_W    = 43;
    localparam int NEXT_W    = 63;
    localparam int CFG_IDX_W = 3;
    localparam int S_DATA_W  = 80;
    localparam int S_USER_W  = 2;
    localparam int M_DATA_W  = 56;

    localparam logic [RT_W-1:0]    RT_RESET   = 16'd20000;
    localparam logic [LEVEL_W-1:0] MIN_RESET  = 24'd105472;
    localparam logic [LEVEL_W-1:0] GAS_RESET  = 24'd384000;
    localparam logic [LEVEL_W-1:0] SPAN_RESET = 24'd38400;
    localparam logic [LEVEL_W-1:0] MAX_RESET  = 24'd0;
    localparam logic [9:0]         MS_TO_US   = 10'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESPONSE_TIME = 3'd0,
        CFG_MIN_LEVEL     = 3'd1,
        CFG_GAS_LEVEL     = 3'd2,
        CFG_GAS_SPAN      = 3'd3,
        CFG_MAX_LEVEL     = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SETUP_TGT,
        CMD_SETUP_RATE,
        CMD_MUL_LO,
        CMD_MUL_HI,
        CMD_DIV_BOX,
        CMD_DIV_DEN,
        CMD_TARGET,
        CMD_STEP,
        CMD_COMMIT
    } cmd_t;

    typedef struct packed {
        logic track;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

// File: sv/gsrm_div.sv
module gsrm_div
    import gsrm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DEN_W-1:0]  divisor,
    output logic [DIVD_W-1:0] quotient,
    output logic              done
);

    localparam logic [5:0] LAST_STEP = 6'(DIVD_W - 1);

    logic [DIVD_W-1:0] dq_reg, dq_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  dvs_reg, dvs_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    shifted;
    logic [DEN_W:0]    trial;
    logic              fits;

    assign shifted = {rem_reg, dq_reg[DIVD_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            dq_next   = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            dq_next  = {dq_reg[DIVD_W-2:0], fits};
            rem_next = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = dq_reg;
    assign done     = done_reg;

endmodule

// File: sv/gsrm_dp.sv
module gsrm_dp
    import gsrm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEVEL_W-1:0]   cfg_data,
    input  logic [S_DATA_W-1:0]  s_tdata,
    input  logic [S_USER_W-1:0]  s_tuser,
    input  cmd_t                 cmd,
    output dp_status_t           status,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,
    output logic [0:0]           m_tuser
);

    logic [RT_W-1:0]    rt_reg;
    logic [LEVEL_W-1:0] min_reg, gas_reg, span_reg, max_reg;
    logic [LEVEL_W-1:0] reading_reg, reading_next;
    logic               m_valid_reg, m_valid_next;

    logic [TICK_W-1:0]         tick_reg;
    logic [DIST_W-1:0]         dist_reg, box_reg;
    logic signed [NOISE_W-1:0] noise_reg;
    logic                      det_reg;
    logic [DEN_W-1:0]          den_reg;
    logic [MAG_W-1:0]          mag_reg, mag_next;
    logic [TICK_W-1:0]         mb_reg, mb_next;
    logic [ACC_W-1:0]          acc_reg, acc_next;
    logic                      neg_reg, neg_next;
    logic signed [NEXT_W-1:0]  next_reg;
    logic [NOISY_W-1:0]        out_noisy_reg;
    logic [LEVEL_W-1:0]        out_clean_reg;
    logic                      out_gp_reg;

    logic [RT_W-1:0]          rt_eff;
    logic [DEN_W-1:0]         den_calc;
    logic [DIST_W-1:0]        box_in;
    logic signed [DIST_W:0]   bd;
    logic [DIST_W:0]          bd_mag;
    logic [HALF_W-1:0]        mul_a;
    logic [MPY_W-1:0]         mul_p;
    logic                     div_start;
    logic [DEN_W-1:0]         div_divisor;
    logic [DIVD_W-1:0]        quot;
    logic                     div_done;
    logic signed [DIFF_W-1:0] q_tgt, sq_tgt, diff, diff_mag;
    logic signed [NEXT_W-1:0] q_step, s_step, step_sum;
    logic signed [NEXT_W-1:0] min_ext, max_ext, top_ext, c1, c2;
    logic                     max_en;
    logic [LEVEL_W-1:0]       clean;
    logic [NOISY_W-1:0]       noisy;
    logic                     commit;

    assign rt_eff   = (rt_reg == '0) ? RT_W'(1) : rt_reg;
    assign den_calc = DEN_W'(rt_eff) * DEN_W'(MS_TO_US);
    assign box_in   = (s_tdata[51:36] == '0) ? DIST_W'(1) : s_tdata[51:36];

    assign bd     = $signed({1'b0, box_reg}) - $signed({1'b0, dist_reg});
    assign bd_mag = bd[DIST_W] ? DIST_W'(0) - bd : bd;

    assign mul_a = (cmd == CMD_MUL_HI) ? mag_reg[MAG_W-1:HALF_W] : mag_reg[HALF_W-1:0];
    assign mul_p = {{TICK_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mb_reg};

    assign div_start   = (cmd == CMD_DIV_BOX) || (cmd == CMD_DIV_DEN);
    assign div_divisor = (cmd == CMD_DIV_BOX) ? DEN_W'(box_reg) : den_reg;

    gsrm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_reg[DIVD_W-1:0]),
        .divisor  (div_divisor),
        .quotient (quot),
        .done     (div_done)
    );

    assign q_tgt    = $signed({1'b0, quot[MAG_W-1:0]});
    assign sq_tgt   = neg_reg ? -q_tgt : q_tgt;
    assign diff     = $signed({19'd0, gas_reg}) - $signed({19'd0, reading_reg}) + sq_tgt;
    assign diff_mag = diff[DIFF_W-1] ? -diff : diff;

    assign q_step   = $signed({2'b00, quot});
    assign s_step   = neg_reg ? -q_step : q_step;
    assign step_sum = $signed({39'd0, reading_reg}) + s_step;

    assign min_ext = $signed({39'd0, min_reg});
    assign max_ext = $signed({39'd0, max_reg});
    assign top_ext = $signed({39'd0, {LEVEL_W{1'b1}}});
    assign max_en  = (max_reg != '0) && (max_reg >= min_reg);
    assign c1      = (next_reg < min_ext) ? min_ext : next_reg;
    assign c2      = (max_en && (c1 > max_ext)) ? max_ext : c1;
    assign clean   = (c2 > top_ext) ? {LEVEL_W{1'b1}} : c2[LEVEL_W-1:0];
    assign noisy   = {2'b00, clean} + {{(NOISY_W-NOISE_W){noise_reg[NOISE_W-1]}}, noise_reg};

    assign commit = (cmd == CMD_COMMIT);

    always_comb begin
        mag_next     = mag_reg;
        mb_next      = mb_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        reading_next = reading_reg;
        case (cmd)
            CMD_SETUP_TGT: begin
                mag_next = MAG_W'(span_reg);
                mb_next  = TICK_W'(bd_mag);
                neg_next = bd[DIST_W];
            end
            CMD_SETUP_RATE: begin
                mag_next = MAG_W'(gas_reg);
                mb_next  = tick_reg;
                neg_next = !det_reg;
            end
            CMD_MUL_LO: begin
                acc_next = ACC_W'(mul_p);
            end
            CMD_MUL_HI: begin
                acc_next = acc_reg + {mul_p, {HALF_W{1'b0}}};
            end
            CMD_TARGET: begin
                mag_next = diff_mag[MAG_W-1:0];
                mb_next  = tick_reg;
                neg_next = diff[DIFF_W-1];
            end
            CMD_COMMIT: begin
                reading_next = clean;
            end
            default: begin
            end
        endcase
    end

    assign m_valid_next = commit ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rt_reg      <= RT_RESET;
            min_reg     <= MIN_RESET;
            gas_reg     <= GAS_RESET;
            span_reg    <= SPAN_RESET;
            max_reg     <= MAX_RESET;
            reading_reg <= MIN_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            reading_reg <= reading_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_RESPONSE_TIME: rt_reg   <= cfg_data[RT_W-1:0];
                    CFG_MIN_LEVEL:     min_reg  <= cfg_data;
                    CFG_GAS_LEVEL:     gas_reg  <= cfg_data;
                    CFG_GAS_SPAN:      span_reg <= cfg_data;
                    CFG_MAX_LEVEL:     max_reg  <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd == CMD_LOAD) begin
            tick_reg  <= s_tdata[19:0];
            dist_reg  <= s_tdata[35:20];
            box_reg   <= box_in;
            noise_reg <= $signed(s_tdata[72:52]);
            det_reg   <= s_tuser[1];
            den_reg   <= den_calc;
        end
        if (cmd == CMD_STEP) begin
            next_reg <= step_sum;
        end
        if (commit) begin
            out_noisy_reg <= noisy;
            out_clean_reg <= clean;
            out_gp_reg    <= det_reg;
        end
        mag_reg <= mag_next;
        mb_reg  <= mb_next;
        acc_reg <= acc_next;
        neg_reg <= neg_next;
    end

    assign status.track    = det_reg && (reading_reg >= gas_reg);
    assign status.div_done = div_done;
    assign status.out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, out_clean_reg, out_noisy_reg};
    assign m_tuser  = out_gp_reg;

endmodule

// File: sv/gsrm_ctrl.sv
module gsrm_ctrl
    import gsrm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_paused,
    output logic       s_tready,
    output cmd_t       cmd,
    input  dp_status_t status
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b0_0000_0001,
        ST_SETUP    = 9'b0_0000_0010,
        ST_MUL_LO   = 9'b0_0000_0100,
        ST_MUL_HI   = 9'b0_0000_1000,
        ST_DIV_GO   = 9'b0_0001_0000,
        ST_DIV_WAIT = 9'b0_0010_0000,
        ST_TARGET   = 9'b0_0100_0000,
        ST_STEP     = 9'b0_1000_0000,
        ST_COMMIT   = 9'b1_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   tgt_reg, tgt_next;

    always_comb begin
        state_next = state_reg;
        tgt_next   = tgt_reg;
        cmd        = CMD_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd = CMD_LOAD;
                    if (!s_paused) begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                cmd        = status.track ? CMD_SETUP_TGT : CMD_SETUP_RATE;
                tgt_next   = status.track;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                cmd        = CMD_MUL_LO;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd        = CMD_MUL_HI;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                cmd        = tgt_reg ? CMD_DIV_BOX : CMD_DIV_DEN;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (status.div_done) begin
                    state_next = tgt_reg ? ST_TARGET : ST_STEP;
                end
            end
            ST_TARGET: begin
                cmd        = CMD_TARGET;
                tgt_next   = 1'b0;
                state_next = ST_MUL_LO;
            end
            ST_STEP: begin
                cmd        = CMD_STEP;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (status.out_free) begin
                    cmd        = CMD_COMMIT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tgt_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            tgt_reg   <= tgt_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

// File: sv/gas_sensor_response_model_unit.sv
// Gas sensor response model. Each beat on the slave stream is one simulation
// tick; an unpaused tick yields one result beat on the master stream holding
// the clamped reading, the reading plus the supplied noise, and the detection
// flag. A paused tick is accepted while idle and yields nothing.
// Configuration registers are written through the cfg channel, which is
// always ready; the user must write them only while no tick is in flight,
// since the block itself does not enforce this.
// A tick outside an emitter, or inside one while the reading is below the
// base level, runs the shared restoring divider once; a tracking tick runs
// it twice. The divider retires one quotient bit per cycle over 61 steps,
// and each run follows the low and high products of the shared multiplier.
// Ticks are processed one at a time; s_tready is high only while idle, so
// the next tick is accepted only once the previous one has committed.
// A finished result sits in the output register, and the next tick may be
// accepted while it waits. If the receiver stalls, the following tick
// completes its arithmetic and then holds until the output register frees.
// Reset restores every configuration register to its default and sets the
// reading to the default floor level.
module gas_sensor_response_model_unit
    import gsrm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEVEL_W-1:0]   cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tick_us, origin_dist_mm, box_extent_mm, noise_sample
    input  logic [S_DATA_W-1:0]  s_tdata,
    // paused, inside_emitter
    input  logic [S_USER_W-1:0]  s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // noisy_level, clean_level
    output logic [M_DATA_W-1:0]  m_tdata,
    // gas_present
    output logic [0:0]           m_tuser
);

    cmd_t       cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    gsrm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_paused (s_tuser[0]),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    gsrm_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// File: sv/gsrm_chk.sv
module gsrm_chk
    import gsrm_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_USER_W-1:0] s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [0:0]          m_tuser
);

    logic signed [NOISY_W:0] lvl_gap;

    assign lvl_gap = $signed({m_tdata[NOISY_W-1], m_tdata[NOISY_W-1:0]})
                   - $signed({3'b000, m_tdata[49:26]});

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_noise_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (lvl_gap >= -27'sd1048576) && (lvl_gap <= 27'sd1048575))
        else $error("noisy level differs from clean level by more than a noise sample");

    a_paused_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] && !m_tvalid |=> !m_tvalid)
        else $error("paused tick produced a result");

    a_busy_after_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser[0] |=> !s_tready)
        else $error("new tick accepted while one is being computed");

endmodule

bind gas_sensor_response_model_unit gsrm_chk u_gsrm_chk (.*);
